// ===== hw/rtl/tle_pkg.sv =====
package tle_pkg;

  // Default geometry of the screen
  localparam int DEF_LINE_WIDTH = 80;
  localparam int DEF_ROW_COUNT  = 64;

  // Field widths of the channels
  localparam int KEY_W    = 8;
  localparam int CHAR_W   = 8;
  localparam int COLOUR_W = 8;
  localparam int RROW_W   = 6;
  localparam int RCOL_W   = 7;
  localparam int WORD_W   = CHAR_W + COLOUR_W;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'h08;
  localparam logic [KEY_W-1:0] KEY_DELETE    = 8'h7F;
  localparam logic [KEY_W-1:0] KEY_LEFT      = 8'h1B;
  localparam logic [KEY_W-1:0] KEY_RIGHT     = 8'h1A;
  localparam logic [KEY_W-1:0] KEY_HOME      = 8'h02;
  localparam logic [KEY_W-1:0] KEY_END       = 8'h03;
  localparam logic [KEY_W-1:0] KEY_RETURN    = 8'h0D;

  // Cell contents after reset
  localparam logic [CHAR_W-1:0]   SPACE_CHAR   = 8'h20;
  localparam logic [COLOUR_W-1:0] COLOUR_RESET = 8'h0F;

  // Key classes seen by the controller
  localparam int KCLS_W = 3;
  localparam logic [KCLS_W-1:0] KC_CHAR  = 3'd0;
  localparam logic [KCLS_W-1:0] KC_BACK  = 3'd1;
  localparam logic [KCLS_W-1:0] KC_DEL   = 3'd2;
  localparam logic [KCLS_W-1:0] KC_LEFT  = 3'd3;
  localparam logic [KCLS_W-1:0] KC_RIGHT = 3'd4;
  localparam logic [KCLS_W-1:0] KC_HOME  = 3'd5;
  localparam logic [KCLS_W-1:0] KC_END   = 3'd6;
  localparam logic [KCLS_W-1:0] KC_RET   = 3'd7;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic item_load;
    logic clr_wr;
    logic rd_cell;
    logic shift_rd;
    logic shift_left;
    logic scan_load_up;
    logic scan_load_down;
    logic scan_load_last;
    logic scan_inc;
    logic scan_dec;
    logic end_rd;
    logic end_set;
    logic col_dec;
    logic col_inc;
    logic col_zero;
    logic row_next;
    logic ins_wr;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic              clr_last;
    logic              mode;
    logic [KCLS_W-1:0] kcls;
    logic              col_zero;
    logic              col_last;
    logic              scan_eq_x;
    logic              scan_last;
    logic              scan_zero;
    logic              end_hit;
    logic              out_free;
  } dp_stat_t;

  function automatic logic [KCLS_W-1:0] key_class(input logic [KEY_W-1:0] key);
    logic [KCLS_W-1:0] cls;
    unique case (key)
      KEY_BACKSPACE: cls = KC_BACK;
      KEY_DELETE:    cls = KC_DEL;
      KEY_LEFT:      cls = KC_LEFT;
      KEY_RIGHT:     cls = KC_RIGHT;
      KEY_HOME:      cls = KC_HOME;
      KEY_END:       cls = KC_END;
      KEY_RETURN:    cls = KC_RET;
      default:       cls = KC_CHAR;
    endcase
    return cls;
  endfunction

endpackage

// ===== hw/rtl/tle_in_if.sv =====
interface tle_in_if;
  import tle_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [KEY_W-1:0]  key_code;
  logic [RROW_W-1:0] read_row;
  logic [RCOL_W-1:0] read_column;

  modport source (output valid, mode, key_code, read_row, read_column, input ready);
  modport sink   (input valid, mode, key_code, read_row, read_column, output ready);
endinterface

// ===== hw/rtl/tle_out_if.sv =====
interface tle_out_if;
  import tle_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   cell_char;
  logic [COLOUR_W-1:0] cell_colour;
  logic [RCOL_W-1:0]   cursor_column;
  logic [RROW_W-1:0]   cursor_row;
  logic                line_done;

  modport source (output valid, cell_char, cell_colour, cursor_column, cursor_row,
                  line_done, input ready);
  modport sink   (input valid, cell_char, cell_colour, cursor_column, cursor_row,
                  line_done, output ready);
endinterface

// ===== hw/rtl/tle_ctrl.sv =====
module tle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tle_pkg::dp_stat_t  stat,
  output tle_pkg::dp_cmd_t   cmd
);
  import tle_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_SHL      = 4'd3;
  localparam logic [3:0] S_SHL_RUN  = 4'd4;
  localparam logic [3:0] S_SHL_TAIL = 4'd5;
  localparam logic [3:0] S_SHR_RUN  = 4'd6;
  localparam logic [3:0] S_SHR_TAIL = 4'd7;
  localparam logic [3:0] S_INS      = 4'd8;
  localparam logic [3:0] S_END_RUN  = 4'd9;
  localparam logic [3:0] S_END_TAIL = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequence the work of one request
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        if (stat.mode) begin
          cmd.rd_cell = 1'b1;
        end else begin
          unique case (stat.kcls)
            KC_BACK: begin
              if (!stat.col_zero) begin
                cmd.col_dec = 1'b1;
                state_nxt   = S_SHL;
              end
            end
            KC_DEL:   state_nxt = S_SHL;
            KC_LEFT:  cmd.col_dec = !stat.col_zero;
            KC_RIGHT: cmd.col_inc = !stat.col_last;
            KC_HOME:  cmd.col_zero = 1'b1;
            KC_END: begin
              cmd.scan_load_last = 1'b1;
              state_nxt          = S_END_RUN;
            end
            KC_RET: begin
              cmd.row_next = 1'b1;
              cmd.col_zero = 1'b1;
            end
            default: begin
              if (stat.col_last) begin
                state_nxt = S_INS;
              end else begin
                cmd.scan_load_down = 1'b1;
                state_nxt          = S_SHR_RUN;
              end
            end
          endcase
        end
      end
      S_SHL: begin
        if (stat.col_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_load_up = 1'b1;
          state_nxt        = S_SHL_RUN;
        end
      end
      // Read each cell right of the cursor; the datapath writes it one place left
      S_SHL_RUN: begin
        cmd.shift_rd   = 1'b1;
        cmd.shift_left = 1'b1;
        if (stat.scan_last) state_nxt = S_SHL_TAIL;
        else                cmd.scan_inc = 1'b1;
      end
      S_SHL_TAIL: state_nxt = S_DONE;
      // Read from the cell before the last down to the cursor; each is written one place right
      S_SHR_RUN: begin
        cmd.shift_rd = 1'b1;
        if (stat.scan_eq_x) state_nxt = S_SHR_TAIL;
        else                cmd.scan_dec = 1'b1;
      end
      S_SHR_TAIL: state_nxt = S_INS;
      S_INS: begin
        cmd.ins_wr  = 1'b1;
        cmd.col_inc = !stat.col_last;
        state_nxt   = S_DONE;
      end
      // Search leftward for the last non-space cell
      S_END_RUN: begin
        if (stat.end_hit) begin
          cmd.end_set = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.end_rd = 1'b1;
          if (stat.scan_zero) state_nxt = S_END_TAIL;
          else                cmd.scan_dec = 1'b1;
        end
      end
      S_END_TAIL: begin
        if (stat.end_hit) cmd.end_set  = 1'b1;
        else              cmd.col_zero = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hw/rtl/tle_dp.sv =====
module tle_dp #(
  parameter int LINE_WIDTH = tle_pkg::DEF_LINE_WIDTH,
  parameter int ROW_COUNT  = tle_pkg::DEF_ROW_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tle_pkg::dp_cmd_t              cmd,
  output tle_pkg::dp_stat_t             stat,
  input  logic                          in_mode,
  input  logic [tle_pkg::KEY_W-1:0]     in_key_code,
  input  logic [tle_pkg::RROW_W-1:0]    in_read_row,
  input  logic [tle_pkg::RCOL_W-1:0]    in_read_column,
  input  logic                          cfg_we,
  input  logic [tle_pkg::COLOUR_W-1:0]  cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [tle_pkg::CHAR_W-1:0]    out_cell_char,
  output logic [tle_pkg::COLOUR_W-1:0]  out_cell_colour,
  output logic [tle_pkg::RCOL_W-1:0]    out_cursor_column,
  output logic [tle_pkg::RROW_W-1:0]    out_cursor_row,
  output logic                          out_line_done
);
  import tle_pkg::*;

  localparam int CELLS = LINE_WIDTH * ROW_COUNT;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(LINE_WIDTH);
  localparam int RW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam logic [CW-1:0] LAST_COL  = CW'(LINE_WIDTH - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROW_COUNT - 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  // Screen memory: colour in the upper byte, character in the lower
  logic [WORD_W-1:0] mem_r [CELLS];
  logic [WORD_W-1:0] q_r;

  logic              mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [RROW_W-1:0] rrow_r;
  logic [RCOL_W-1:0] rcol_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [AW-1:0] rd_addr_r;
  logic          dir_r;
  logic          pend_r;
  logic          chk_r;
  logic [CW-1:0] chk_col_r;
  logic [AW-1:0] clr_addr_r;
  logic [COLOUR_W-1:0] colour_r;

  logic [AW-1:0]     base_addr, cur_addr, scan_addr, cell_addr, rd_addr, wb_addr, wr_addr;
  logic              in_range, rd_en, wr_en;
  logic [WORD_W-1:0] wr_data;

  // Addresses
  assign base_addr = AW'(row_r * LINE_WIDTH);
  assign cur_addr  = base_addr + AW'(col_r);
  assign scan_addr = base_addr + AW'(scan_r);
  assign cell_addr = AW'(32'(rrow_r) * LINE_WIDTH + 32'(rcol_r));
  assign in_range  = (32'(rrow_r) < ROW_COUNT) && (32'(rcol_r) < LINE_WIDTH);
  assign wb_addr   = dir_r ? (rd_addr_r - AW'(1)) : (rd_addr_r + AW'(1));

  assign rd_en   = (cmd.rd_cell && in_range) || cmd.shift_rd || cmd.end_rd;
  assign rd_addr = cmd.rd_cell ? cell_addr : scan_addr;

  // Select the one write of this cycle
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cur_addr;
    wr_data = {colour_r, key_r};
    priority if (cmd.clr_wr) begin
      wr_addr = clr_addr_r;
      wr_data = {COLOUR_RESET, SPACE_CHAR};
    end else if (pend_r) begin
      wr_addr = wb_addr;
      wr_data = q_r;
    end else if (cmd.ins_wr) begin
      wr_addr = cur_addr;
      wr_data = {colour_r, key_r};
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) q_r <= mem_r[rd_addr];
  end

  // Cursor and scan counter
  always_comb begin
    col_nxt = col_r;
    priority if (cmd.col_dec)  col_nxt = col_r - CW'(1);
    else if (cmd.col_inc)      col_nxt = col_r + CW'(1);
    else if (cmd.col_zero)     col_nxt = '0;
    else if (cmd.end_set)      col_nxt = (chk_col_r == LAST_COL) ? LAST_COL
                                                                : chk_col_r + CW'(1);
    else                       col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.row_next) row_nxt = (row_r == LAST_ROW) ? '0 : row_r + RW'(1);
    scan_nxt = scan_r;
    priority if (cmd.scan_load_up)  scan_nxt = col_r + CW'(1);
    else if (cmd.scan_load_down)    scan_nxt = LAST_COL - CW'(1);
    else if (cmd.scan_load_last)    scan_nxt = LAST_COL;
    else if (cmd.scan_inc)          scan_nxt = scan_r + CW'(1);
    else if (cmd.scan_dec)          scan_nxt = scan_r - CW'(1);
    else                            scan_nxt = scan_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      pend_r      <= 1'b0;
      chk_r       <= 1'b0;
      clr_addr_r  <= '0;
      colour_r    <= COLOUR_RESET;
      out_valid   <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= cmd.shift_rd;
      chk_r  <= cmd.end_rd;
      if (cmd.clr_wr) clr_addr_r <= clr_addr_r + AW'(1);
      if (cfg_we)     colour_r   <= cfg_data;
      if (cmd.out_load)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    if (cmd.item_load) begin
      mode_r <= in_mode;
      key_r  <= in_key_code;
      rrow_r <= in_read_row;
      rcol_r <= in_read_column;
    end
    if (cmd.shift_rd) begin
      rd_addr_r <= scan_addr;
      dir_r     <= cmd.shift_left;
    end
    if (cmd.end_rd) chk_col_r <= scan_r;
    if (cmd.out_load) begin
      out_cell_char     <= (mode_r && in_range) ? q_r[CHAR_W-1:0] : '0;
      out_cell_colour   <= (mode_r && in_range) ? q_r[WORD_W-1:CHAR_W] : '0;
      out_cursor_column <= RCOL_W'(col_r);
      out_cursor_row    <= RROW_W'(row_r);
      out_line_done     <= !mode_r && (key_class(key_r) == KC_RET);
    end
  end

  // Status toward the controller
  always_comb begin
    stat.clr_last  = (clr_addr_r == LAST_CELL);
    stat.mode      = mode_r;
    stat.kcls      = key_class(key_r);
    stat.col_zero  = (col_r == '0);
    stat.col_last  = (col_r == LAST_COL);
    stat.scan_eq_x = (scan_r == col_r);
    stat.scan_last = (scan_r == LAST_COL);
    stat.scan_zero = (scan_r == '0);
    stat.end_hit   = chk_r && (q_r[CHAR_W-1:0] != SPACE_CHAR);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

// ===== hw/rtl/text_line_editor_core.sv =====
// Each request is decoded, then its result loads in DONE once the output is free.
// Reads, cursor keys and return go straight to DONE; insert and delete shift the cells
// right of the cursor (backspace moves it left first); end searches the line leftward.
// One request at a time, the next accepted after the result loads; shifts and the end
// search walk the line. Reset: cursor to row 0 column 0, colour 0x0F; a clearing pass
// writes every cell (LINE_WIDTH * ROW_COUNT, 5120 by default) before in ready rises.
module text_line_editor_core #(
  parameter int LINE_WIDTH = tle_pkg::DEF_LINE_WIDTH,
  parameter int ROW_COUNT  = tle_pkg::DEF_ROW_COUNT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tle_in_if.sink                       in_chan,
  tle_out_if.source                    out_chan,
  input  logic                         cfg_we,
  input  logic [tle_pkg::COLOUR_W-1:0] cfg_data
);
  import tle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_chan.ready = in_ready;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tle_dp #(
    .LINE_WIDTH (LINE_WIDTH),
    .ROW_COUNT  (ROW_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_chan.mode),
    .in_key_code       (in_chan.key_code),
    .in_read_row       (in_chan.read_row),
    .in_read_column    (in_chan.read_column),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_cell_char     (out_chan.cell_char),
    .out_cell_colour   (out_chan.cell_colour),
    .out_cursor_column (out_chan.cursor_column),
    .out_cursor_row    (out_chan.cursor_row),
    .out_line_done     (out_chan.line_done)
  );

endmodule
